// ===== hdl/mws_pkg.sv =====
// ----------------------------------------------------------------------------
// mws_pkg
// Shared constants, mark encoding and helpers of the marker watershed core.
// ----------------------------------------------------------------------------
package mws_pkg;

  localparam int unsigned MAX_W   = 64;
  localparam int unsigned MAX_H   = 64;
  localparam int unsigned STRIDE  = MAX_W + 2;
  localparam int unsigned CELLS   = STRIDE * (MAX_H + 2);
  localparam int unsigned PIXELS  = MAX_W * MAX_H;
  localparam int unsigned QCAP    = PIXELS + 2;

  localparam int unsigned CELL_AW = $clog2(CELLS);
  localparam int unsigned PIX_AW  = $clog2(PIXELS);
  localparam int unsigned Q_AW    = $clog2(QCAP + 1);
  localparam int unsigned XW      = $clog2(MAX_W);
  localparam int unsigned YW      = $clog2(MAX_H);
  localparam int unsigned DIM_W   = 7;
  localparam int unsigned LABEL_W = 16;
  localparam int unsigned GREY_W  = 8;
  localparam int unsigned DIST_W  = CELL_AW;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned CLS_W   = 2;

  localparam logic [GREY_W-1:0] LEVEL_LAST = 8'd255;

  localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RUN  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

  localparam logic [CLS_W-1:0] CLS_LABELED   = 2'd0;
  localparam logic [CLS_W-1:0] CLS_WSHED     = 2'd1;
  localparam logic [CLS_W-1:0] CLS_UNREACHED = 2'd2;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    MK_INIT,
    MK_MASK,
    MK_WSHED,
    MK_LABEL
  } mark_kind_e;

  typedef struct packed {
    mark_kind_e          kind;
    logic [LABEL_W-1:0]  label;
  } mark_t;

  localparam int unsigned MARK_W = $bits(mark_t);

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic [CELL_AW-1:0] cell_of(input logic [XW-1:0] x,
                                                 input logic [YW-1:0] y);
    logic [CELL_AW-1:0] xc;
    logic [CELL_AW-1:0] yc;
    xc = CELL_AW'(x) + CELL_AW'(1);
    yc = CELL_AW'(y) + CELL_AW'(1);
    return xc + CELL_AW'(yc * CELL_AW'(STRIDE));
  endfunction

endpackage

// ===== hdl/mws_in_if.sv =====
// ----------------------------------------------------------------------------
// mws_in_if
// Command channel of the marker watershed core.
// ----------------------------------------------------------------------------
interface mws_in_if;
  logic                             valid;
  logic                             ready;
  logic [mws_pkg::CMD_W-1:0]        command;
  logic [mws_pkg::PIX_AW-1:0]       pixel_index;
  logic [mws_pkg::GREY_W-1:0]       intensity;
  logic [mws_pkg::LABEL_W-1:0]      seed_label;

  modport source (output valid, command, pixel_index, intensity, seed_label, input ready);
  modport sink   (input valid, command, pixel_index, intensity, seed_label, output ready);
endinterface

// ===== hdl/mws_out_if.sv =====
// ----------------------------------------------------------------------------
// mws_out_if
// Result channel of the marker watershed core.
// ----------------------------------------------------------------------------
interface mws_out_if;
  logic                             valid;
  logic                             ready;
  logic [mws_pkg::LABEL_W-1:0]      label;
  logic [mws_pkg::CLS_W-1:0]        pixel_class;
  logic                             done_res;

  modport source (output valid, label, pixel_class, done_res, input ready);
  modport sink   (input valid, label, pixel_class, done_res, output ready);
endinterface

// ===== hdl/mws_ram.sv =====
// ----------------------------------------------------------------------------
// mws_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module mws_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/mws_div.sv =====
// ----------------------------------------------------------------------------
// mws_div
// Restoring divider, one quotient bit per cycle: splits a raster index into
// row and column for the active image width.
// ----------------------------------------------------------------------------
module mws_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [mws_pkg::PIX_AW-1:0]  dividend_i,
  input  logic [mws_pkg::DIM_W-1:0]   divisor_i,
  output mws_pkg::div_stat_t          stat_o,
  output logic [mws_pkg::PIX_AW-1:0]  quot_o,
  output logic [mws_pkg::DIM_W-1:0]   rem_o
);

  localparam int unsigned CNT_W = $clog2(mws_pkg::PIX_AW + 1);

  logic [CNT_W-1:0]              cnt_q;
  logic                          busy_q;
  logic                          done_q;
  logic [mws_pkg::PIX_AW-1:0]    quot_q;
  logic [mws_pkg::DIM_W-1:0]     rem_q;
  logic [mws_pkg::DIM_W-1:0]     dvs_q;
  logic [mws_pkg::DIM_W:0]       trial;
  logic                          fits;

  assign trial = {rem_q, quot_q[mws_pkg::PIX_AW-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CNT_W'(mws_pkg::PIX_AW);
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      dvs_q  <= divisor_i;
    end else if (busy_q) begin
      rem_q  <= mws_pkg::DIM_W'(fits ? trial - {1'b0, dvs_q} : trial);
      quot_q <= {quot_q[mws_pkg::PIX_AW-2:0], fits};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quot_q;
  assign rem_o       = rem_q;

endmodule

// ===== hdl/marker_watershed_segmenter_core.sv =====
// ----------------------------------------------------------------------------
// marker_watershed_segmenter_core
// Marker-based 4-connected watershed over a padded 66x66 mark grid.
// ----------------------------------------------------------------------------
// Load and read pass the raster index through the index divider, which splits it
// into row and column, then make one access to the pixel memories. After reset
// the core clears the mark and distance memories (all 4356 cells) and accepts no
// command meanwhile; configuration writes are taken at any time. A run first
// sweeps all 4356 cells (border reset), then for each of the 256 grey levels
// scans the active image pixel by pixel, checks the four neighbours of each
// pixel of that level that was still unmarked, drains the flood queue one
// popped cell at a time, and clears the distances of that level's queued
// cells. Every step is bound by the single read port of the mark memory.
module marker_watershed_segmenter_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  mws_in_if.sink                     in_i,
  mws_out_if.source                  out_o,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [mws_pkg::DIM_W-1:0]  cfg_wdata_i
);

  typedef enum logic [4:0] {
    ST_SWEEP, ST_IDLE, ST_DIV, ST_ACT, ST_RD_USE, ST_RESP,
    ST_SCAN_RD, ST_SCAN_CHK, ST_NB_RD, ST_NB_CHK,
    ST_DR_START, ST_DR_LOOP, ST_DR_POP, ST_T_WAIT, ST_SP_RD, ST_SP_CHK,
    ST_DCLR, ST_DCLR_W
  } state_e;

  localparam int unsigned CA = mws_pkg::CELL_AW;
  localparam int unsigned QA = mws_pkg::Q_AW;
  localparam int unsigned DW = mws_pkg::DIST_W;

  function automatic logic [CA-1:0] nbr_of(input logic [CA-1:0] p, input logic [1:0] k);
    logic [CA-1:0] n;
    case (k)
      2'd0:    n = p + CA'(1);
      2'd1:    n = p - CA'(1);
      2'd2:    n = p + CA'(mws_pkg::STRIDE);
      default: n = p - CA'(mws_pkg::STRIDE);
    endcase
    return n;
  endfunction

  function automatic logic [QA-1:0] q_next(input logic [QA-1:0] p);
    return (p == QA'(mws_pkg::QCAP - 1)) ? '0 : p + QA'(1);
  endfunction

  state_e                          state_q;
  logic                            sweep_all_q;
  logic [CA-1:0]                   sc_q;
  logic [mws_pkg::DIM_W-1:0]       sx_q, sy_q;
  logic [mws_pkg::DIM_W-1:0]       w_q, h_q, w_act, h_act;

  logic [mws_pkg::CMD_W-1:0]       cmd_q;
  logic [mws_pkg::PIX_AW-1:0]      idx_q;
  logic [mws_pkg::GREY_W-1:0]      grey_in_q;
  logic [mws_pkg::LABEL_W-1:0]     seed_q;
  logic [mws_pkg::XW-1:0]          x_q;
  logic [mws_pkg::YW-1:0]          y_q;
  logic                            inside_q;

  logic [mws_pkg::LABEL_W-1:0]     res_label_q, out_label_q;
  logic [mws_pkg::CLS_W-1:0]       res_cls_q, out_cls_q;
  logic                            res_done_q, out_done_q, out_valid_q;

  logic [mws_pkg::GREY_W-1:0]      lev_q;
  logic [mws_pkg::XW-1:0]          px_q;
  logic [mws_pkg::YW-1:0]          py_q;
  logic [1:0]                      nk_q;
  logic                            any_q;
  logic [QA-1:0]                   head_q, tail_q, count_q, lvl_start_q, ptr_q;
  logic [DW-1:0]                   left_q, ring_q;
  logic [CA-1:0]                   p_q;
  mws_pkg::mark_t                  mt_q;

  mws_pkg::div_stat_t              div_stat;
  logic                            div_start;
  logic [mws_pkg::PIX_AW-1:0]      div_quot;
  logic [mws_pkg::DIM_W-1:0]       div_rem;

  logic                            g_we;
  logic [mws_pkg::PIX_AW-1:0]      g_waddr, g_raddr;
  logic [mws_pkg::GREY_W-1:0]      g_rdata;
  logic                            m_we;
  logic [CA-1:0]                   m_waddr, m_raddr;
  mws_pkg::mark_t                  m_wdata, m_rd;
  logic [mws_pkg::MARK_W-1:0]      m_rdata;
  logic                            d_we;
  logic [CA-1:0]                   d_waddr, d_raddr;
  logic [DW-1:0]                   d_wdata, d_rdata;
  logic                            q_we;
  logic [QA-1:0]                   q_raddr;
  logic [CA-1:0]                   q_wdata, q_rdata;

  logic                            in_fire;
  logic [CA-1:0]                   pc, xy_cell, sp_n;
  logic                            outside, last_px, last_py, q_full, push;
  logic                            rn_ge0, sp_push, nb_any;
  mws_pkg::mark_t                  mt_nx;
  logic [CA:0]                     p_hi;

  assign w_act = (w_q == '0) ? mws_pkg::DIM_W'(1) :
                 (w_q > mws_pkg::DIM_W'(mws_pkg::MAX_W)) ? mws_pkg::DIM_W'(mws_pkg::MAX_W) : w_q;
  assign h_act = (h_q == '0) ? mws_pkg::DIM_W'(1) :
                 (h_q > mws_pkg::DIM_W'(mws_pkg::MAX_H)) ? mws_pkg::DIM_W'(mws_pkg::MAX_H) : h_q;

  assign in_fire   = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);
  assign div_start = in_fire && (in_i.command == mws_pkg::CMD_LOAD ||
                                 in_i.command == mws_pkg::CMD_READ);

  assign pc      = mws_pkg::cell_of(px_q, py_q);
  assign xy_cell = mws_pkg::cell_of(x_q, y_q);
  assign sp_n    = nbr_of(p_q, nk_q);
  assign outside = (sy_q == '0) || (sy_q > h_act) || (sx_q == '0) || (sx_q > w_act);
  assign last_px = ({1'b0, px_q} == w_act - mws_pkg::DIM_W'(1));
  assign last_py = ({1'b0, py_q} == h_act - mws_pkg::DIM_W'(1));
  assign q_full  = (count_q == QA'(mws_pkg::QCAP));
  assign m_rd    = m_rdata;
  assign p_hi    = {1'b0, q_rdata} + (CA+1)'(mws_pkg::STRIDE);
  assign rn_ge0  = (m_rd.kind == mws_pkg::MK_WSHED) || (m_rd.kind == mws_pkg::MK_LABEL);
  assign nb_any  = any_q || rn_ge0;

  always_comb begin
    mt_nx   = mt_q;
    sp_push = 1'b0;
    if (rn_ge0 && (d_rdata < ring_q)) begin
      if (m_rd.kind == mws_pkg::MK_LABEL) begin
        if (mt_q.kind == mws_pkg::MK_INIT || mt_q.kind == mws_pkg::MK_MASK) begin
          mt_nx = m_rd;
        end else if (mt_q.kind == mws_pkg::MK_WSHED) begin
          if (({1'b0, d_rdata} + (DW+1)'(1)) < {1'b0, ring_q}) begin
            mt_nx = m_rd;
          end
        end else if (mt_q.label != m_rd.label) begin
          mt_nx.kind  = mws_pkg::MK_WSHED;
          mt_nx.label = '0;
        end
      end else if (mt_q.kind == mws_pkg::MK_MASK) begin
        mt_nx.kind  = mws_pkg::MK_WSHED;
        mt_nx.label = '0;
      end
    end else if (m_rd.kind == mws_pkg::MK_MASK && d_rdata == '0) begin
      sp_push = 1'b1;
    end
  end

  assign push = ((state_q == ST_NB_CHK) && (nk_q == 2'd3) && nb_any) ||
                ((state_q == ST_SP_CHK) && sp_push);

  always_comb begin
    g_we    = 1'b0;
    g_waddr = {y_q, x_q};
    g_raddr = {py_q, px_q};
    m_we    = 1'b0;
    m_waddr = sc_q;
    m_wdata.kind  = mws_pkg::MK_INIT;
    m_wdata.label = '0;
    m_raddr = '0;
    d_we    = 1'b0;
    d_waddr = sp_n;
    d_wdata = '0;
    d_raddr = sp_n;
    q_we    = push && !q_full;
    q_wdata = (state_q == ST_SP_CHK) ? sp_n : pc;
    q_raddr = (state_q == ST_DCLR) ? ptr_q : head_q;
    case (state_q)
      ST_SWEEP: begin
        m_we    = sweep_all_q || outside;
        d_we    = sweep_all_q;
        d_waddr = sc_q;
      end
      ST_ACT: begin
        m_raddr = xy_cell;
        if (cmd_q == mws_pkg::CMD_LOAD && inside_q) begin
          g_we    = 1'b1;
          m_we    = 1'b1;
          m_waddr = xy_cell;
          if (seed_q != '0) begin
            m_wdata.kind  = mws_pkg::MK_LABEL;
            m_wdata.label = seed_q;
          end
        end
      end
      ST_SCAN_RD: m_raddr = pc;
      ST_SCAN_CHK: begin
        if (g_rdata == lev_q && m_rd.kind == mws_pkg::MK_INIT) begin
          m_we         = 1'b1;
          m_waddr      = pc;
          m_wdata.kind = mws_pkg::MK_MASK;
        end
      end
      ST_NB_RD: m_raddr = nbr_of(pc, nk_q);
      ST_NB_CHK: begin
        if (nk_q == 2'd3 && nb_any) begin
          d_we    = 1'b1;
          d_waddr = pc;
          d_wdata = DW'(1);
        end
      end
      ST_DR_POP: m_raddr = q_rdata;
      ST_SP_RD:  m_raddr = sp_n;
      ST_SP_CHK: begin
        m_we    = (mt_nx != mt_q);
        m_waddr = p_q;
        m_wdata = mt_nx;
        d_we    = sp_push;
        d_wdata = ring_q + DW'(1);
      end
      ST_DCLR_W: begin
        d_we    = 1'b1;
        d_waddr = q_rdata;
      end
      default: ;
    endcase
  end

  mws_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (in_i.pixel_index),
    .divisor_i  (w_act),
    .stat_o     (div_stat),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  mws_ram #(.WIDTH(mws_pkg::GREY_W), .DEPTH(mws_pkg::PIXELS)) u_grey (
    .clk_i(clk_i), .we_i(g_we), .waddr_i(g_waddr), .wdata_i(grey_in_q),
    .raddr_i(g_raddr), .rdata_o(g_rdata)
  );

  mws_ram #(.WIDTH(mws_pkg::MARK_W), .DEPTH(mws_pkg::CELLS)) u_mark (
    .clk_i(clk_i), .we_i(m_we), .waddr_i(m_waddr), .wdata_i(m_wdata),
    .raddr_i(m_raddr), .rdata_o(m_rdata)
  );

  mws_ram #(.WIDTH(DW), .DEPTH(mws_pkg::CELLS)) u_dist (
    .clk_i(clk_i), .we_i(d_we), .waddr_i(d_waddr), .wdata_i(d_wdata),
    .raddr_i(d_raddr), .rdata_o(d_rdata)
  );

  mws_ram #(.WIDTH(CA), .DEPTH(mws_pkg::QCAP)) u_queue (
    .clk_i(clk_i), .we_i(q_we), .waddr_i(tail_q), .wdata_i(q_wdata),
    .raddr_i(q_raddr), .rdata_o(q_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SWEEP;
      sweep_all_q <= 1'b1;
      sc_q        <= '0;
      sx_q        <= '0;
      sy_q        <= '0;
      w_q         <= mws_pkg::DIM_W'(mws_pkg::MAX_W);
      h_q         <= mws_pkg::DIM_W'(mws_pkg::MAX_H);
      out_valid_q <= 1'b0;
      cmd_q       <= '0;
      lev_q       <= '0;
      px_q        <= '0;
      py_q        <= '0;
      nk_q        <= '0;
      any_q       <= 1'b0;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      lvl_start_q <= '0;
      ptr_q       <= '0;
      left_q      <= '0;
      ring_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          mws_pkg::REG_WIDTH:  w_q <= cfg_wdata_i;
          mws_pkg::REG_HEIGHT: h_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (q_we) begin
        tail_q  <= q_next(tail_q);
        count_q <= count_q + QA'(1);
      end
      case (state_q)
        ST_SWEEP: begin
          sc_q <= sc_q + CA'(1);
          if (sx_q == mws_pkg::DIM_W'(mws_pkg::STRIDE - 1)) begin
            sx_q <= '0;
            sy_q <= sy_q + mws_pkg::DIM_W'(1);
          end else begin
            sx_q <= sx_q + mws_pkg::DIM_W'(1);
          end
          if (sc_q == CA'(mws_pkg::CELLS - 1)) begin
            if (sweep_all_q) begin
              state_q <= ST_IDLE;
            end else begin
              head_q      <= '0;
              tail_q      <= '0;
              count_q     <= '0;
              lvl_start_q <= '0;
              ring_q      <= '0;
              lev_q       <= '0;
              px_q        <= '0;
              py_q        <= '0;
              state_q     <= ST_SCAN_RD;
            end
          end
        end
        ST_IDLE: begin
          if (in_fire) begin
            cmd_q     <= in_i.command;
            idx_q     <= in_i.pixel_index;
            grey_in_q <= in_i.intensity;
            seed_q    <= in_i.seed_label;
            case (in_i.command)
              mws_pkg::CMD_LOAD, mws_pkg::CMD_READ: state_q <= ST_DIV;
              mws_pkg::CMD_RUN: begin
                sweep_all_q <= 1'b0;
                sc_q        <= '0;
                sx_q        <= '0;
                sy_q        <= '0;
                state_q     <= ST_SWEEP;
              end
              default: begin
                res_label_q <= '0;
                res_cls_q   <= mws_pkg::CLS_LABELED;
                res_done_q  <= 1'b0;
                state_q     <= ST_RESP;
              end
            endcase
          end
        end
        ST_DIV: begin
          if (div_stat.done) begin
            x_q      <= div_rem[mws_pkg::XW-1:0];
            y_q      <= div_quot[mws_pkg::YW-1:0];
            inside_q <= div_quot < mws_pkg::PIX_AW'(h_act);
            state_q  <= ST_ACT;
          end
        end
        ST_ACT: begin
          res_label_q <= '0;
          res_cls_q   <= mws_pkg::CLS_LABELED;
          res_done_q  <= 1'b1;
          if (cmd_q == mws_pkg::CMD_READ && !inside_q) begin
            res_cls_q <= mws_pkg::CLS_UNREACHED;
            state_q   <= ST_RESP;
          end else if (cmd_q == mws_pkg::CMD_READ) begin
            state_q <= ST_RD_USE;
          end else begin
            state_q <= ST_RESP;
          end
        end
        ST_RD_USE: begin
          case (m_rd.kind)
            mws_pkg::MK_LABEL: begin
              res_label_q <= m_rd.label;
              res_cls_q   <= mws_pkg::CLS_LABELED;
            end
            mws_pkg::MK_WSHED: res_cls_q <= mws_pkg::CLS_WSHED;
            default:           res_cls_q <= mws_pkg::CLS_UNREACHED;
          endcase
          state_q <= ST_RESP;
        end
        ST_RESP: begin
          if (!out_valid_q || out_o.ready) begin
            out_label_q <= res_label_q;
            out_cls_q   <= res_cls_q;
            out_done_q  <= res_done_q;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        ST_SCAN_RD: state_q <= ST_SCAN_CHK;
        ST_SCAN_CHK, ST_NB_CHK: begin
          if (state_q == ST_SCAN_CHK && g_rdata == lev_q && m_rd.kind == mws_pkg::MK_INIT) begin
            nk_q    <= '0;
            any_q   <= 1'b0;
            state_q <= ST_NB_RD;
          end else if (state_q == ST_NB_CHK && nk_q != 2'd3) begin
            nk_q    <= nk_q + 2'd1;
            any_q   <= nb_any;
            state_q <= ST_NB_RD;
          end else if (last_px) begin
            px_q <= '0;
            if (last_py) begin
              state_q <= ST_DR_START;
            end else begin
              py_q    <= py_q + mws_pkg::YW'(1);
              state_q <= ST_SCAN_RD;
            end
          end else begin
            px_q    <= px_q + mws_pkg::XW'(1);
            state_q <= ST_SCAN_RD;
          end
        end
        ST_NB_RD: state_q <= ST_NB_CHK;
        ST_DR_START: begin
          ring_q  <= DW'(1);
          left_q  <= DW'(count_q);
          state_q <= ST_DR_LOOP;
        end
        ST_DR_LOOP: begin
          if (left_q == '0) begin
            if (count_q == '0) begin
              ptr_q   <= lvl_start_q;
              state_q <= ST_DCLR;
            end else begin
              ring_q <= ring_q + DW'(1);
              left_q <= DW'(count_q);
            end
          end else begin
            head_q  <= q_next(head_q);
            count_q <= count_q - QA'(1);
            left_q  <= left_q - DW'(1);
            state_q <= ST_DR_POP;
          end
        end
        ST_DR_POP: begin
          p_q  <= q_rdata;
          nk_q <= '0;
          if (q_rdata < CA'(mws_pkg::STRIDE) || p_hi >= (CA+1)'(mws_pkg::CELLS)) begin
            state_q <= ST_DR_LOOP;
          end else begin
            state_q <= ST_T_WAIT;
          end
        end
        ST_T_WAIT: begin
          mt_q    <= m_rd;
          state_q <= ST_SP_RD;
        end
        ST_SP_RD: state_q <= ST_SP_CHK;
        ST_SP_CHK: begin
          mt_q <= mt_nx;
          if (nk_q == 2'd3) begin
            state_q <= ST_DR_LOOP;
          end else begin
            nk_q    <= nk_q + 2'd1;
            state_q <= ST_SP_RD;
          end
        end
        ST_DCLR: begin
          if (ptr_q == tail_q) begin
            if (lev_q == mws_pkg::LEVEL_LAST) begin
              res_label_q <= '0;
              res_cls_q   <= mws_pkg::CLS_LABELED;
              res_done_q  <= 1'b1;
              state_q     <= ST_RESP;
            end else begin
              lev_q       <= lev_q + mws_pkg::GREY_W'(1);
              lvl_start_q <= head_q;
              px_q        <= '0;
              py_q        <= '0;
              state_q     <= ST_SCAN_RD;
            end
          end else begin
            ptr_q   <= q_next(ptr_q);
            state_q <= ST_DCLR_W;
          end
        end
        ST_DCLR_W: state_q <= ST_DCLR;
        default:   state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.label       = out_label_q;
  assign out_o.pixel_class = out_cls_q;
  assign out_o.done_res    = out_done_q;

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QA'(mws_pkg::QCAP))
    else $error("flood queue count beyond capacity");

  a_drain_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DR_LOOP && left_q == '0 && count_q == '0) |-> head_q == tail_q)
    else $error("flood queue pointers disagree with empty count");

  a_push_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_we |-> (q_wdata >= CA'(mws_pkg::STRIDE) &&
              ({1'b0, q_wdata} + (CA+1)'(mws_pkg::STRIDE)) < (CA+1)'(mws_pkg::CELLS)))
    else $error("border cell pushed into flood queue");

endmodule

// ===== tb/sv/marker_watershed_segmenter_core_tb.sv =====
// ----------------------------------------------------------------------------
// marker_watershed_segmenter_core_tb
// Drives load, run, read and unknown commands through the watershed core over
// small images and checks every result against an in-bench flooding predictor
// ----------------------------------------------------------------------------
module marker_watershed_segmenter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mws_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
  localparam int MK_INIT_V  = -1;
  localparam int MK_MASK_V  = -2;
  localparam int MK_WSHED_V = 0;
  localparam int STALL_LIMIT = 200000;

  typedef struct {
    logic [LABEL_W-1:0] label;
    logic [CLS_W-1:0]   pclass;
    logic               done;
  } seg_result_t;

  typedef struct {
    logic [CMD_W-1:0]   cmd;
    logic [PIX_AW-1:0]  idx;
    logic [GREY_W-1:0]  grey;
    logic [LABEL_W-1:0] seed;
    bit                 typed;
    logic [LABEL_W-1:0] label;
    logic [CLS_W-1:0]   pclass;
    logic               done;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = 1'b0;
  logic [DIM_W-1:0] cfg_wdata_i = '0;

  mws_in_if  cmd_if ();
  mws_out_if res_if ();

  marker_watershed_segmenter_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (cmd_if),
    .out_o       (res_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [GREY_W-1:0] grey_mem [PIXELS];
  int                marks    [CELLS];
  int unsigned       rings    [CELLS];
  int unsigned       fifo     [QCAP];
  int unsigned       fifo_head, fifo_count, ring_now;
  logic [DIM_W-1:0]  width_reg, height_reg;

  seg_result_t pending_q[$];
  int  errors = 0;
  bit  no_gaps = 1'b0;
  int  idle_cycles = 0;

  function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v);
    if (v < 1) return 1;
    if (v > 64) return 64;
    return v;
  endfunction

  function automatic void fifo_push(int unsigned c);
    if (fifo_count >= QCAP) return;
    fifo[(fifo_head + fifo_count) % QCAP] = c;
    fifo_count++;
  endfunction

  function automatic void flood_spread(int unsigned t, int unsigned n);
    int rn;
    int rt;
    int unsigned dn;
    if (t >= CELLS || n >= CELLS) return;
    rn = marks[n];
    dn = rings[n];
    if (rn >= 0 && dn < ring_now) begin
      rt = marks[t];
      if (rn > 0) begin
        if (rt < 0) marks[t] = rn;
        else if (rt == MK_WSHED_V) begin
          if (dn + 1 < ring_now) marks[t] = rn;
        end else if (rt != rn) marks[t] = MK_WSHED_V;
      end else if (rt == MK_MASK_V) begin
        marks[t] = MK_WSHED_V;
      end
    end else if (rn == MK_MASK_V && dn == 0) begin
      rings[n] = ring_now + 1;
      fifo_push(n);
    end
  endfunction

  function automatic void flood_image();
    int unsigned w, h, c, p, left;
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    for (int unsigned y = 0; y < MAX_H + 2; y++)
      for (int unsigned x = 0; x < STRIDE; x++)
        if (y < 1 || y > h || x < 1 || x > w) marks[y * STRIDE + x] = MK_INIT_V;
    foreach (rings[i]) rings[i] = 0;
    fifo_head = 0;
    fifo_count = 0;
    ring_now = 0;
    for (int unsigned lev = 0; lev < 256; lev++) begin
      for (int unsigned y = 0; y < h; y++) begin
        for (int unsigned x = 0; x < w; x++) begin
          c = (x + 1) + (y + 1) * STRIDE;
          if (grey_mem[y * MAX_W + x] != lev) continue;
          if (marks[c] != MK_INIT_V) continue;
          marks[c] = MK_MASK_V;
          if (marks[c + 1] >= 0 || marks[c - 1] >= 0 ||
              marks[c + STRIDE] >= 0 || marks[c - STRIDE] >= 0) begin
            rings[c] = 1;
            fifo_push(c);
          end
        end
      end
      ring_now = 1;
      left = fifo_count;
      forever begin
        if (left == 0) begin
          if (fifo_count == 0) break;
          ring_now++;
          left = fifo_count;
        end
        p = fifo[fifo_head % QCAP];
        fifo_head = (fifo_head + 1) % QCAP;
        fifo_count--;
        left--;
        if (p < STRIDE || p + STRIDE >= CELLS) continue;
        flood_spread(p, p + 1);
        flood_spread(p, p - 1);
        flood_spread(p, p + STRIDE);
        flood_spread(p, p - STRIDE);
      end
      foreach (rings[i]) rings[i] = 0;
    end
  endfunction

  function automatic seg_result_t segment_step(logic [CMD_W-1:0] cmd, logic [PIX_AW-1:0] idx,
                                               logic [GREY_W-1:0] grey,
                                               logic [LABEL_W-1:0] seed);
    seg_result_t r;
    int unsigned w, h, x, y, c;
    int m;
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    x = idx % w;
    y = idx / w;
    c = (x + 1) + (y + 1) * STRIDE;
    r = '{label: '0, pclass: CLS_LABELED, done: 1'b1};
    case (cmd)
      CMD_LOAD: begin
        if (y < h) begin
          grey_mem[y * MAX_W + x] = grey;
          marks[c] = (seed != 0) ? int'(seed) : MK_INIT_V;
        end
      end
      CMD_RUN: flood_image();
      CMD_READ: begin
        if (y >= h) r.pclass = CLS_UNREACHED;
        else begin
          m = marks[c];
          if (m > 0) r.label = m[LABEL_W-1:0];
          else if (m == MK_WSHED_V) r.pclass = CLS_WSHED;
          else r.pclass = CLS_UNREACHED;
        end
      end
      default: r.done = 1'b0;
    endcase
    return r;
  endfunction

  function automatic int draw_gap();
    if (no_gaps) return 0;
    return $urandom_range(0, 12);
  endfunction

  task automatic send_cmd(logic [CMD_W-1:0] cmd, logic [PIX_AW-1:0] idx,
                          logic [GREY_W-1:0] grey, logic [LABEL_W-1:0] seed,
                          bit typed = 1'b0, seg_result_t typed_res = '{'0, '0, 1'b0});
    int gap;
    seg_result_t r;
    gap = draw_gap();
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_if.valid       <= 1'b1;
    cmd_if.command     <= cmd;
    cmd_if.pixel_index <= idx;
    cmd_if.intensity   <= grey;
    cmd_if.seed_label  <= seed;
    do @(posedge clk_i); while (!(cmd_if.valid && cmd_if.ready));
    r = segment_step(cmd, idx, grey, seed);
    pending_q.push_back(typed ? typed_res : r);
  endtask

  task automatic drain_results();
    cmd_if.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [DIM_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_WIDTH) width_reg = val;
    else height_reg = val;
  endtask

  task automatic send_noise();
    case ($urandom_range(0, 2))
      0: send_cmd(CMD_UNKNOWN, PIX_AW'($urandom), GREY_W'($urandom), LABEL_W'($urandom));
      1: send_cmd(CMD_READ, PIX_AW'($urandom), GREY_W'($urandom), LABEL_W'($urandom));
      default: send_cmd(CMD_LOAD, PIX_AW'($urandom_range(3000, 4095)), GREY_W'($urandom),
                        LABEL_W'($urandom));
    endcase
  endtask

  task automatic random_phase(ref int sent);
    logic [DIM_W-1:0] w_val, h_val;
    int unsigned npix, nlev;
    logic [GREY_W-1:0] base;
    logic [LABEL_W-1:0] seed;
    int pick;
    pick = $urandom_range(0, 9);
    w_val = DIM_W'($urandom_range(1, 6));
    h_val = DIM_W'($urandom_range(1, 6));
    case (pick)
      0: begin w_val = 7'd64;  h_val = DIM_W'($urandom_range(1, 2)); end
      1: begin w_val = 7'd127; h_val = 7'd0; end
      2: begin h_val = 7'd64;  w_val = DIM_W'($urandom_range(1, 2)); end
      3: begin h_val = 7'd127; w_val = 7'd0; end
      default: ;
    endcase
    write_reg(REG_WIDTH, w_val);
    write_reg(REG_HEIGHT, h_val);
    no_gaps = ($urandom_range(0, 3) == 0);
    npix = clamp_dim(w_val) * clamp_dim(h_val);
    nlev = ($urandom_range(0, 1) == 0) ? 4 : 256;
    base = GREY_W'($urandom);
    for (int unsigned i = 0; i < npix; i++) begin
      if ($urandom_range(0, 9) == 0) begin send_noise(); sent++; end
      seed = '0;
      if ($urandom_range(0, 5) == 0)
        seed = ($urandom_range(0, 3) == 0) ? LABEL_W'($urandom) : LABEL_W'($urandom_range(1, 4));
      send_cmd(CMD_LOAD, PIX_AW'(i), GREY_W'(base + $urandom_range(0, nlev - 1)), seed);
      sent++;
    end
    send_cmd(CMD_RUN, '0, GREY_W'($urandom), LABEL_W'($urandom));
    sent++;
    if ($urandom_range(0, 4) == 0) begin
      send_cmd(CMD_LOAD, PIX_AW'($urandom_range(0, npix - 1)), GREY_W'($urandom), '0);
      send_cmd(CMD_RUN, PIX_AW'($urandom), '0, '0);
      sent += 2;
    end
    for (int unsigned i = 0; i < npix; i++) begin
      if ($urandom_range(0, 9) == 0) begin send_noise(); sent++; end
      send_cmd(CMD_READ, PIX_AW'(i), GREY_W'($urandom), LABEL_W'($urandom));
      sent++;
    end
    drain_results();
  endtask

  stim_row_t dir_rows [23] = '{
    '{CMD_READ,    12'd0,    8'h00, 16'h0000, 1, 16'h0000, CLS_UNREACHED, 1'b1},
    '{CMD_UNKNOWN, 12'd4095, 8'hff, 16'hffff, 1, 16'h0000, CLS_LABELED,   1'b0},
    '{CMD_READ,    12'd4095, 8'h00, 16'h0000, 1, 16'h0000, CLS_UNREACHED, 1'b1},
    '{CMD_LOAD,    12'd4095, 8'hff, 16'hffff, 1, 16'h0000, CLS_LABELED,   1'b1},
    '{CMD_LOAD,    12'd0,    8'h00, 16'h0001, 1, 16'h0000, CLS_LABELED,   1'b1},
    '{CMD_LOAD,    12'd1,    8'hff, 16'h0000, 1, 16'h0000, CLS_LABELED,   1'b1},
    '{CMD_LOAD,    12'd2,    8'h07, 16'hffff, 1, 16'h0000, CLS_LABELED,   1'b1},
    '{CMD_LOAD,    12'd3,    8'h80, 16'h0000, 1, 16'h0000, CLS_LABELED,   1'b1},
    '{CMD_LOAD,    12'd4,    8'h80, 16'h0000, 1, 16'h0000, CLS_LABELED,   1'b1},
    '{CMD_LOAD,    12'd5,    8'h00, 16'h8000, 1, 16'h0000, CLS_LABELED,   1'b1},
    '{CMD_READ,    12'd2,    8'h00, 16'h0000, 1, 16'hffff, CLS_LABELED,   1'b1},
    '{CMD_READ,    12'd1,    8'h00, 16'h0000, 1, 16'h0000, CLS_UNREACHED, 1'b1},
    '{CMD_RUN,     12'd0,    8'h00, 16'h0000, 1, 16'h0000, CLS_LABELED,   1'b1},
    '{CMD_READ,    12'd0,    8'h00, 16'h0000, 0, 16'h0000, CLS_LABELED,   1'b0},
    '{CMD_READ,    12'd1,    8'h00, 16'h0000, 0, 16'h0000, CLS_LABELED,   1'b0},
    '{CMD_READ,    12'd2,    8'h00, 16'h0000, 0, 16'h0000, CLS_LABELED,   1'b0},
    '{CMD_READ,    12'd3,    8'h00, 16'h0000, 0, 16'h0000, CLS_LABELED,   1'b0},
    '{CMD_READ,    12'd4,    8'h00, 16'h0000, 0, 16'h0000, CLS_LABELED,   1'b0},
    '{CMD_READ,    12'd5,    8'h00, 16'h0000, 0, 16'h0000, CLS_LABELED,   1'b0},
    '{CMD_LOAD,    12'd4,    8'h03, 16'h0000, 1, 16'h0000, CLS_LABELED,   1'b1},
    '{CMD_RUN,     12'd0,    8'h00, 16'h0000, 1, 16'h0000, CLS_LABELED,   1'b1},
    '{CMD_READ,    12'd4,    8'h00, 16'h0000, 0, 16'h0000, CLS_LABELED,   1'b0},
    '{CMD_READ,    12'd6,    8'h00, 16'h0000, 1, 16'h0000, CLS_UNREACHED, 1'b1}
  };

  initial begin
    int sent;
    sent = 0;
    cmd_if.valid = 1'b0;
    cmd_if.command = CMD_LOAD;
    cmd_if.pixel_index = '0;
    cmd_if.intensity = '0;
    cmd_if.seed_label = '0;
    foreach (grey_mem[i]) grey_mem[i] = '0;
    foreach (marks[i]) marks[i] = MK_INIT_V;
    foreach (rings[i]) rings[i] = 0;
    fifo_head = 0;
    fifo_count = 0;
    ring_now = 0;
    width_reg = 7'd64;
    height_reg = 7'd64;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_reg(REG_WIDTH, 7'd3);
    write_reg(REG_HEIGHT, 7'd2);
    foreach (dir_rows[i])
      send_cmd(dir_rows[i].cmd, dir_rows[i].idx, dir_rows[i].grey, dir_rows[i].seed,
               dir_rows[i].typed, '{dir_rows[i].label, dir_rows[i].pclass, dir_rows[i].done});
    drain_results();
    while (sent < 900) random_phase(sent);
    drain_results();
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    int gap;
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(res_if.valid && res_if.ready));
    end
  end

  always @(posedge clk_i) begin
    seg_result_t exp_r;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_q.size() == 0) begin
        $error("unexpected result transfer: label %0h class %0d done %0b",
               res_if.label, res_if.pixel_class, res_if.done_res);
        errors++;
      end else begin
        exp_r = pending_q.pop_front();
        if (res_if.label !== exp_r.label) begin
          $error("label: expected %0h, got %0h", exp_r.label, res_if.label);
          errors++;
        end
        if (res_if.pixel_class !== exp_r.pclass) begin
          $error("pixel_class: expected %0d, got %0d", exp_r.pclass, res_if.pixel_class);
          errors++;
        end
        if (res_if.done_res !== exp_r.done) begin
          $error("done_res: expected %0b, got %0b", exp_r.done, res_if.done_res);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $error("timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// ===== marker_watershed_segmenter_core.f =====
hdl/mws_pkg.sv
hdl/mws_in_if.sv
hdl/mws_out_if.sv
hdl/mws_ram.sv
hdl/mws_div.sv
hdl/marker_watershed_segmenter_core.sv
tb/sv/marker_watershed_segmenter_core_tb.sv
